// ===== design/file_delivery_receiver_fsm_defines.svh =====
// Assertion macros for the file delivery receiver checker.
// No dependencies; included by the checker file only.
`ifndef FILE_DELIVERY_RECEIVER_FSM_DEFINES_SVH
`define FILE_DELIVERY_RECEIVER_FSM_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define FDR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define FDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fdr_pkg.sv =====
// Shared types and codes for the file delivery receiver.
// No dependencies; imported by every module of the block.
package fdr_pkg;

    typedef enum logic [3:0] {
        ACT_ENTERED     = 4'd0,
        ACT_ABANDON     = 4'd1,
        ACT_CANCEL_NOTE = 4'd2,
        ACT_METADATA    = 4'd3,
        ACT_FILEDATA    = 4'd4,
        ACT_EOF_OK      = 4'd5,
        ACT_EOF_CANCEL  = 4'd6,
        ACT_TIMEOUT     = 4'd7,
        ACT_CANCEL_REQ  = 4'd8,
        ACT_REPORT      = 4'd9
    } action_t;

    localparam logic [2:0] IND_NONE      = 3'd0;
    localparam logic [2:0] IND_METADATA  = 3'd1;
    localparam logic [2:0] IND_SEGMENT   = 3'd2;
    localparam logic [2:0] IND_EOF       = 3'd3;
    localparam logic [2:0] IND_REPORT    = 3'd4;
    localparam logic [2:0] IND_ABANDONED = 3'd5;
    localparam logic [2:0] IND_UNSUP     = 3'd6;

    localparam logic [1:0] FK_INACTIVITY = 2'd0;
    localparam logic [1:0] FK_FILE_SIZE  = 2'd1;
    localparam logic [1:0] FK_CHECKSUM   = 2'd2;

    localparam logic [1:0] ST_WAIT_MD  = 2'd0;
    localparam logic [1:0] ST_WAIT_EOF = 2'd1;
    localparam logic [1:0] ST_DONE     = 2'd2;

    localparam logic [3:0] COND_NONE       = 4'd0;
    localparam logic [3:0] COND_CANCEL_REQ = 4'd15;

    typedef struct packed {
        logic [3:0]  action;
        logic        transfer_in_progress;
        logic [31:0] segment_start;
        logic [15:0] segment_length;
        logic [31:0] eof_file_size;
        logic [31:0] eof_checksum;
        logic [31:0] computed_checksum;
        logic [3:0]  eof_condition;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  indication;
        logic        finished;
        logic        fault_raised;
        logic [1:0]  fault_kind;
        logic        cancel_requested;
        logic        open_temp_file;
        logic        store_segment;
        logic        commit_file;
        logic [1:0]  current_state;
        logic [3:0]  held_condition;
        logic        data_complete;
        logic [31:0] bytes_received;
    } result_t;

endpackage

// ===== design/fdr_input_stage.sv =====
// Input register of the file delivery receiver: holds one accepted event.
// Depends on fdr_pkg for the event struct.
module fdr_input_stage
    import fdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // stall only while the held event cannot move on this cycle
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/fdr_core.sv =====
// Receiver state machine and result register: one event per transfer.
// Depends on fdr_pkg for codes, the event struct and the result struct.
module fdr_core
    import fdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  in_item_t item,
    output logic     take,
    input  logic     out_stall,
    output logic     res_valid,
    output result_t  res
);

    typedef enum logic [1:0] {
        PH_WAIT_MD  = ST_WAIT_MD,
        PH_WAIT_EOF = ST_WAIT_EOF,
        PH_DONE     = ST_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  cond_reg, cond_next;
    logic        complete_reg, complete_next;
    logic [31:0] high_reg, high_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;

    logic        out_free;
    logic [32:0] seg_sum;
    logic [31:0] seg_end;

    assign out_free = !res_valid_reg || !out_stall;
    assign take     = item_valid && out_free;

    // saturate the segment end at the top of the 32-bit range
    assign seg_sum = {1'b0, item.segment_start} + {17'd0, item.segment_length};
    assign seg_end = seg_sum[32] ? 32'hFFFF_FFFF : seg_sum[31:0];

    always_comb
    begin
        phase_next    = phase_reg;
        cond_next     = cond_reg;
        complete_next = complete_reg;
        high_next     = high_reg;
        res_next      = '0;

        if (phase_reg == PH_WAIT_MD || phase_reg == PH_WAIT_EOF)
        begin
            case (action_t'(item.action))
                ACT_ENTERED:
                begin
                    if (phase_reg == PH_WAIT_MD)
                    begin
                        phase_next    = PH_WAIT_MD;
                        cond_next     = COND_NONE;
                        complete_next = 1'b0;
                        high_next     = '0;
                    end
                    else
                    begin
                        res_next.indication = IND_UNSUP;
                    end
                end
                ACT_ABANDON:
                begin
                    res_next.indication = IND_ABANDONED;
                    phase_next          = PH_DONE;
                end
                ACT_CANCEL_NOTE:
                begin
                    res_next.finished = 1'b1;
                    phase_next        = PH_DONE;
                end
                ACT_METADATA:
                begin
                    if (phase_reg == PH_WAIT_MD)
                    begin
                        res_next.indication     = IND_METADATA;
                        res_next.open_temp_file = item.transfer_in_progress;
                        phase_next              = PH_WAIT_EOF;
                    end
                    else
                    begin
                        res_next.indication = IND_UNSUP;
                    end
                end
                ACT_FILEDATA:
                begin
                    if (phase_reg == PH_WAIT_EOF)
                    begin
                        res_next.indication = IND_SEGMENT;
                        if (item.transfer_in_progress)
                        begin
                            res_next.store_segment = 1'b1;
                            if (high_reg < seg_end)
                            begin
                                high_next = seg_end;
                            end
                        end
                    end
                    else
                    begin
                        res_next.indication = IND_UNSUP;
                    end
                end
                ACT_EOF_OK:
                begin
                    if (phase_reg == PH_WAIT_MD)
                    begin
                        res_next.finished = 1'b1;
                        phase_next        = PH_DONE;
                    end
                    else
                    begin
                        res_next.indication = IND_EOF;
                        // size check takes priority over the checksum
                        if (item.transfer_in_progress && high_reg > item.eof_file_size)
                        begin
                            res_next.fault_raised = 1'b1;
                            res_next.fault_kind   = FK_FILE_SIZE;
                        end
                        else if (item.transfer_in_progress &&
                                 item.computed_checksum != item.eof_checksum)
                        begin
                            res_next.fault_raised = 1'b1;
                            res_next.fault_kind   = FK_CHECKSUM;
                        end
                        else
                        begin
                            if (item.transfer_in_progress)
                            begin
                                complete_next        = 1'b1;
                                res_next.commit_file = 1'b1;
                            end
                            res_next.finished = 1'b1;
                            phase_next        = PH_DONE;
                        end
                    end
                end
                ACT_EOF_CANCEL:
                begin
                    cond_next         = item.eof_condition;
                    res_next.finished = 1'b1;
                    phase_next        = PH_DONE;
                end
                ACT_TIMEOUT:
                begin
                    res_next.fault_raised = 1'b1;
                    res_next.fault_kind   = FK_INACTIVITY;
                end
                ACT_CANCEL_REQ:
                begin
                    cond_next                 = COND_CANCEL_REQ;
                    res_next.cancel_requested = 1'b1;
                end
                ACT_REPORT:
                begin
                    res_next.indication = IND_REPORT;
                end
                default:
                begin
                    res_next.indication = IND_UNSUP;
                end
            endcase
        end

        res_next.current_state  = phase_next;
        res_next.held_condition = cond_next;
        res_next.data_complete  = complete_next;
        res_next.bytes_received = high_next;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT_MD;
            cond_reg      <= COND_NONE;
            complete_reg  <= 1'b0;
            high_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                phase_reg    <= phase_next;
                cond_reg     <= cond_next;
                complete_reg <= complete_next;
                high_reg     <= high_next;
                res_reg      <= res_next;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/file_delivery_receiver_fsm.sv =====
// Top level of the unacknowledged file delivery receiver state machine.
// Depends on fdr_pkg, fdr_input_stage and fdr_core.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------------
//  events   | in_valid / in_stall   | action, transfer_in_progress, segment and
//           |                       | EOF fields, computed_checksum, eof_condition
//  results  | out_valid / out_stall | indication, flags, fault_kind, phase,
//           |                       | condition, data_complete, bytes_received
//
// One event per cycle sustained while results are not stalled; each event's result
// passes the input register, then the state update into the result register.
// The state update sets the rate: each event sees the state left by the one
// before it.
// Reset clears the phase to waiting for metadata, the condition code, the
// data-complete flag, the high-water mark and both valid flags.
// A stall on the results side holds the result register and propagates to
// in_stall in the same cycle only while the input register is also full.
module file_delivery_receiver_fsm
    import fdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  action,
    input  logic        transfer_in_progress,
    input  logic [31:0] segment_start,
    input  logic [15:0] segment_length,
    input  logic [31:0] eof_file_size,
    input  logic [31:0] eof_checksum,
    input  logic [31:0] computed_checksum,
    input  logic [3:0]  eof_condition,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  indication,
    output logic        finished,
    output logic        fault_raised,
    output logic [1:0]  fault_kind,
    output logic        cancel_requested,
    output logic        open_temp_file,
    output logic        store_segment,
    output logic        commit_file,
    output logic [1:0]  current_state,
    output logic [3:0]  held_condition,
    output logic        data_complete,
    output logic [31:0] bytes_received
);

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     take;
    result_t  res;

    // gather the event fields into one word for the input register
    assign in_item.action               = action;
    assign in_item.transfer_in_progress = transfer_in_progress;
    assign in_item.segment_start        = segment_start;
    assign in_item.segment_length       = segment_length;
    assign in_item.eof_file_size        = eof_file_size;
    assign in_item.eof_checksum         = eof_checksum;
    assign in_item.computed_checksum    = computed_checksum;
    assign in_item.eof_condition        = eof_condition;

    // hold one event until the state machine can take it
    fdr_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // advance the phase and register the result of each event
    fdr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_stall  (out_stall),
        .res_valid  (out_valid),
        .res        (res)
    );

    // spread the result register over the output ports
    assign indication       = res.indication;
    assign finished         = res.finished;
    assign fault_raised     = res.fault_raised;
    assign fault_kind       = res.fault_kind;
    assign cancel_requested = res.cancel_requested;
    assign open_temp_file   = res.open_temp_file;
    assign store_segment    = res.store_segment;
    assign commit_file      = res.commit_file;
    assign current_state    = res.current_state;
    assign held_condition   = res.held_condition;
    assign data_complete    = res.data_complete;
    assign bytes_received   = res.bytes_received;

endmodule

// ===== design/fdr_checker.sv =====
// Port-level checker for the file delivery receiver, bound to the top level.
// Depends on fdr_pkg and file_delivery_receiver_fsm_defines.svh.
`include "file_delivery_receiver_fsm_defines.svh"

module fdr_checker
    import fdr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  indication,
    input logic        finished,
    input logic        fault_raised,
    input logic [1:0]  fault_kind,
    input logic        open_temp_file,
    input logic        commit_file,
    input logic [1:0]  current_state,
    input logic        data_complete,
    input logic [31:0] bytes_received
);

    // a held result keeps its phase and high-water mark
    `FDR_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(current_state) && $stable(bytes_received), "stalled result changed")

    // a fault kind other than inactivity only comes with a fault
    `FDR_ASSERT_NOW(a_fault_kind, out_valid && fault_kind != FK_INACTIVITY, fault_raised && !finished, "fault kind without fault")

    // committing the file finishes the transaction as data complete
    `FDR_ASSERT_NOW(a_commit, out_valid && commit_file, finished && data_complete && current_state == ST_DONE && indication == IND_EOF, "commit without completion")

    // data complete is only ever seen once the transaction has completed
    `FDR_ASSERT_NOW(a_complete_done, out_valid && data_complete, current_state == ST_DONE, "data complete outside completed phase")

    // opening the temporary file moves the receiver on to wait for EOF
    `FDR_ASSERT_NOW(a_open_meta, out_valid && open_temp_file, indication == IND_METADATA && current_state == ST_WAIT_EOF, "open file outside metadata")

endmodule

bind file_delivery_receiver_fsm fdr_checker u_fdr_checker (.*);

// ===== dv/tb_file_delivery_receiver_fsm.sv =====
// Self-checking testbench for the file delivery receiver state machine.
// Depends on fdr_pkg and file_delivery_receiver_fsm; a directed table and a random
// phase are checked, result by result, against a predictor of the delivery state.
module tb_file_delivery_receiver_fsm;
    import fdr_pkg::*;

    // Action codes past the last named event are all unsupported.
    localparam logic [3:0]  ACT_FIRST_UNSUP = 4'd10;
    localparam logic [3:0]  ACT_LAST_UNSUP  = 4'd15;
    localparam logic [31:0] MAX32           = 32'hFFFF_FFFF;
    localparam logic [15:0] MAX16           = 16'hFFFF;

    localparam int RANDOM_EVENTS  = 820;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    // One row of the directed table: the event, and a typed-in result where the
    // expectation is plain at a glance (otherwise the predictor supplies it).
    typedef struct packed {
        in_item_t ev;
        logic     typed;
        result_t  want;
    } stim_row_t;

    logic     clk      = 1'b0;
    logic     rst_n    = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    in_item_t ev_bus   = '0;
    logic     out_stall = 1'b0;

    logic        out_valid;
    logic [2:0]  indication;
    logic        finished;
    logic        fault_raised;
    logic [1:0]  fault_kind;
    logic        cancel_requested;
    logic        open_temp_file;
    logic        store_segment;
    logic        commit_file;
    logic [1:0]  current_state;
    logic [3:0]  held_condition;
    logic        data_complete;
    logic [31:0] bytes_received;
    result_t     seen;

    // Predicted delivery state, kept in step with every accepted event.
    logic [1:0]  phase_q    = ST_WAIT_MD;
    logic [3:0]  cond_q     = COND_NONE;
    logic        complete_q = 1'b0;
    logic [31:0] hw_mark    = '0;

    result_t   pending_results[$];
    stim_row_t directed_rows[$];
    int        closing_start;
    int        fail_count  = 0;
    int        idle_cycles = 0;
    int        burst_left  = 0;
    int        stall_left  = 0;
    int        stall_pick;
    result_t   oldest_want;

    // 4 time unit clock, high then low.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    file_delivery_receiver_fsm i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .action               (ev_bus.action),
        .transfer_in_progress (ev_bus.transfer_in_progress),
        .segment_start        (ev_bus.segment_start),
        .segment_length       (ev_bus.segment_length),
        .eof_file_size        (ev_bus.eof_file_size),
        .eof_checksum         (ev_bus.eof_checksum),
        .computed_checksum    (ev_bus.computed_checksum),
        .eof_condition        (ev_bus.eof_condition),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .indication           (indication),
        .finished             (finished),
        .fault_raised         (fault_raised),
        .fault_kind           (fault_kind),
        .cancel_requested     (cancel_requested),
        .open_temp_file       (open_temp_file),
        .store_segment        (store_segment),
        .commit_file          (commit_file),
        .current_state        (current_state),
        .held_condition       (held_condition),
        .data_complete        (data_complete),
        .bytes_received       (bytes_received)
    );

    // Gather the result ports in the field order of result_t.
    assign seen = {indication, finished, fault_raised, fault_kind, cancel_requested,
                   open_temp_file, store_segment, commit_file, current_state,
                   held_condition, data_complete, bytes_received};

    // Return the predicted state to its values after reset.
    function automatic void clear_delivery_state();
        phase_q    = ST_WAIT_MD;
        cond_q     = COND_NONE;
        complete_q = 1'b0;
        hw_mark    = '0;
    endfunction

    // Advance the predicted state by one event and return the result it causes.
    function automatic result_t next_delivery_result(input in_item_t ev);
        result_t     r;
        logic [32:0] seg_sum;
        logic [31:0] seg_end;
        logic        in_md;
        logic        in_eof;
        r      = '0;
        in_md  = (phase_q == ST_WAIT_MD);
        in_eof = (phase_q == ST_WAIT_EOF);
        // Completed (and the unused fourth phase code) ignores every event.
        if (in_md || in_eof)
        begin
            case (ev.action)
                ACT_ENTERED:
                begin
                    if (in_md)
                        clear_delivery_state();
                    else
                        r.indication = IND_UNSUP;
                end
                ACT_ABANDON:
                begin
                    r.indication = IND_ABANDONED;
                    phase_q      = ST_DONE;
                end
                ACT_CANCEL_NOTE:
                begin
                    r.finished = 1'b1;
                    phase_q    = ST_DONE;
                end
                ACT_METADATA:
                begin
                    if (in_md)
                    begin
                        r.indication     = IND_METADATA;
                        r.open_temp_file = ev.transfer_in_progress;
                        phase_q          = ST_WAIT_EOF;
                    end
                    else
                        r.indication = IND_UNSUP;
                end
                ACT_FILEDATA:
                begin
                    if (in_eof)
                    begin
                        r.indication = IND_SEGMENT;
                        if (ev.transfer_in_progress)
                        begin
                            // Saturate the segment end at the top of the 32-bit range.
                            seg_sum = {1'b0, ev.segment_start} + {17'd0, ev.segment_length};
                            seg_end = seg_sum[32] ? MAX32 : seg_sum[31:0];
                            r.store_segment = 1'b1;
                            if (hw_mark < seg_end)
                                hw_mark = seg_end;
                        end
                    end
                    else
                        r.indication = IND_UNSUP;
                end
                ACT_EOF_OK:
                begin
                    if (in_md)
                    begin
                        r.finished = 1'b1;
                        phase_q    = ST_DONE;
                    end
                    else
                    begin
                        r.indication = IND_EOF;
                        // Size is checked before the checksum; a fault holds the phase.
                        if (ev.transfer_in_progress && hw_mark > ev.eof_file_size)
                        begin
                            r.fault_raised = 1'b1;
                            r.fault_kind   = FK_FILE_SIZE;
                        end
                        else if (ev.transfer_in_progress &&
                                 ev.computed_checksum != ev.eof_checksum)
                        begin
                            r.fault_raised = 1'b1;
                            r.fault_kind   = FK_CHECKSUM;
                        end
                        else
                        begin
                            if (ev.transfer_in_progress)
                            begin
                                complete_q    = 1'b1;
                                r.commit_file = 1'b1;
                            end
                            r.finished = 1'b1;
                            phase_q    = ST_DONE;
                        end
                    end
                end
                ACT_EOF_CANCEL:
                begin
                    cond_q     = ev.eof_condition;
                    r.finished = 1'b1;
                    phase_q    = ST_DONE;
                end
                ACT_TIMEOUT:
                begin
                    r.fault_raised = 1'b1;
                    r.fault_kind   = FK_INACTIVITY;
                end
                ACT_CANCEL_REQ:
                begin
                    cond_q             = COND_CANCEL_REQ;
                    r.cancel_requested = 1'b1;
                end
                ACT_REPORT:
                    r.indication = IND_REPORT;
                default:
                    r.indication = IND_UNSUP;
            endcase
        end
        r.current_state  = (phase_q > ST_DONE) ? ST_DONE : phase_q;
        r.held_condition = cond_q;
        r.data_complete  = complete_q;
        r.bytes_received = hw_mark;
        return r;
    endfunction

    // Mostly back-to-back transfers, some short gaps, a few long ones, and
    // occasional bursts with no gap at all.
    function automatic int pick_gap();
        int pick;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_item_t random_fields();
        in_item_t ev;
        ev.action               = 4'($urandom_range(0, 15));
        ev.transfer_in_progress = 1'($urandom_range(0, 1));
        ev.segment_start        = $urandom();
        ev.segment_length       = 16'($urandom_range(0, 65535));
        ev.eof_file_size        = $urandom();
        ev.eof_checksum         = $urandom();
        ev.computed_checksum    = $urandom();
        ev.eof_condition        = 4'($urandom_range(0, 15));
        return ev;
    endfunction

    // Present one event, hold it until the transfer, then record its expectation.
    // Valid is lowered only when a gap follows, so it never toggles within a step.
    task automatic send_event(input in_item_t ev, input logic typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_bus   <= ev;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = next_delivery_result(ev);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Random events while waiting for EOF. Completion is final and reset comes
    // only once, so every EOF here is made to fault; the run ends in one
    // closing event instead.
    task automatic send_random_event();
        in_item_t    ev;
        int          pick;
        logic [31:0] span;
        ev   = random_fields();
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            ev.action               = ACT_FILEDATA;
            ev.transfer_in_progress = ($urandom_range(0, 9) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 5)
                ev.segment_start = $urandom_range(0, 32'h000F_FFFF);
            else if (pick < 9)
            begin
                // Land just below the high-water mark, so the end may or may not pass it.
                span = (hw_mark < 32'd65535) ? hw_mark : 32'd65535;
                ev.segment_start = hw_mark - $urandom_range(0, span);
            end
        end
        else if (pick < 70)
        begin
            ev.action               = ACT_EOF_OK;
            ev.transfer_in_progress = 1'b1;
            case ($urandom_range(0, 3))
                0:       ev.eof_file_size = hw_mark - 32'd1;
                1:       ev.eof_file_size = hw_mark;
                2:       ev.eof_file_size = hw_mark + $urandom_range(1, 1000);
                default: ;
            endcase
            if ($urandom_range(0, 1) != 0)
                ev.computed_checksum = ev.eof_checksum;
            // Where the size passes, break the checksum by one bit.
            if (!(hw_mark > ev.eof_file_size) && ev.computed_checksum == ev.eof_checksum)
                ev.computed_checksum = ev.eof_checksum ^ (32'd1 << $urandom_range(0, 31));
        end
        else if (pick < 78)
            ev.action = ACT_TIMEOUT;
        else if (pick < 83)
            ev.action = ACT_CANCEL_REQ;
        else if (pick < 88)
            ev.action = ACT_REPORT;
        else if (pick < 94)
            ev.action = 4'($urandom_range(ACT_FIRST_UNSUP, ACT_LAST_UNSUP));
        else if (pick < 97)
            ev.action = ACT_ENTERED;
        else
            ev.action = ACT_METADATA;
        send_event(ev, 1'b0, '0);
    endtask

    function automatic string fmt_result(input result_t r);
        return $sformatf({"ind=%0d fin=%0b flt=%0b fk=%0d canc=%0b open=%0b store=%0b ",
                          "commit=%0b st=%0d cond=%0d dc=%0b bytes=%08h"},
                         r.indication, r.finished, r.fault_raised, r.fault_kind,
                         r.cancel_requested, r.open_temp_file, r.store_segment,
                         r.commit_file, r.current_state, r.held_condition,
                         r.data_complete, r.bytes_received);
    endfunction

    function automatic logic results_differ(input result_t a, input result_t b);
        return (a.indication       !== b.indication)       ||
               (a.finished         !== b.finished)         ||
               (a.fault_raised     !== b.fault_raised)     ||
               (a.fault_kind       !== b.fault_kind)       ||
               (a.cancel_requested !== b.cancel_requested) ||
               (a.open_temp_file   !== b.open_temp_file)   ||
               (a.store_segment    !== b.store_segment)    ||
               (a.commit_file      !== b.commit_file)      ||
               (a.current_state    !== b.current_state)    ||
               (a.held_condition   !== b.held_condition)   ||
               (a.data_complete    !== b.data_complete)    ||
               (a.bytes_received   !== b.bytes_received);
    endfunction

    task automatic log_failure(input string what, input result_t want, input result_t got);
        if (fail_count < REPORT_LIMIT)
            $display("%0t %s: expected %s, got %s", $time, what,
                     fmt_result(want), fmt_result(got));
        fail_count++;
    endtask

    // Receiver stall: free-running stretches, short stalls and a few long ones.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 45)
            begin
                out_stall <= 1'b0;
                stall_left = $urandom_range(1, 40);
            end
            else if (stall_pick < 92)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(1, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
        else
            stall_left = stall_left - 1;
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                log_failure("result with nothing expected", '0, seen);
            else
            begin
                oldest_want = pending_results.pop_front();
                if (results_differ(oldest_want, seen))
                    log_failure("result mismatch", oldest_want, seen);
            end
        end
    end

    // Drop the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_file_delivery_receiver_fsm failed");
            $finish;
        end
    end

    initial
    begin
        in_item_t ev;
        logic [4:0] code;

        // Opening rows: waiting for metadata, then the step into waiting for EOF.
        directed_rows.push_back('{in_item_t'{ACT_ENTERED, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b1,
                                  result_t'{IND_NONE, 1'b0, 1'b0, FK_INACTIVITY, 1'b0, 1'b0,
                                            1'b0, 1'b0, ST_WAIT_MD, COND_NONE, 1'b0, 32'd0}});
        directed_rows.push_back('{in_item_t'{ACT_TIMEOUT, 1'b1, MAX32, MAX16, MAX32, MAX32,
                                             MAX32, 4'hF}, 1'b1,
                                  result_t'{IND_NONE, 1'b0, 1'b1, FK_INACTIVITY, 1'b0, 1'b0,
                                            1'b0, 1'b0, ST_WAIT_MD, COND_NONE, 1'b0, 32'd0}});
        directed_rows.push_back('{in_item_t'{ACT_CANCEL_REQ, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b1,
                                  result_t'{IND_NONE, 1'b0, 1'b0, FK_INACTIVITY, 1'b1, 1'b0,
                                            1'b0, 1'b0, ST_WAIT_MD, COND_CANCEL_REQ, 1'b0,
                                            32'd0}});
        directed_rows.push_back('{in_item_t'{ACT_REPORT, 1'b1, 32'd0, 16'd0, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b1,
                                  result_t'{IND_REPORT, 1'b0, 1'b0, FK_INACTIVITY, 1'b0, 1'b0,
                                            1'b0, 1'b0, ST_WAIT_MD, COND_CANCEL_REQ, 1'b0,
                                            32'd0}});
        directed_rows.push_back('{in_item_t'{ACT_FIRST_UNSUP, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b1,
                                  result_t'{IND_UNSUP, 1'b0, 1'b0, FK_INACTIVITY, 1'b0, 1'b0,
                                            1'b0, 1'b0, ST_WAIT_MD, COND_CANCEL_REQ, 1'b0,
                                            32'd0}});
        directed_rows.push_back('{in_item_t'{ACT_LAST_UNSUP, 1'b1, MAX32, MAX16, MAX32, MAX32,
                                             MAX32, 4'hF}, 1'b1,
                                  result_t'{IND_UNSUP, 1'b0, 1'b0, FK_INACTIVITY, 1'b0, 1'b0,
                                            1'b0, 1'b0, ST_WAIT_MD, COND_CANCEL_REQ, 1'b0,
                                            32'd0}});
        // File data before metadata is out of phase.
        directed_rows.push_back('{in_item_t'{ACT_FILEDATA, 1'b1, 32'd5, 16'd7, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        // Entered while waiting for metadata wipes the cancel condition.
        directed_rows.push_back('{in_item_t'{ACT_ENTERED, 1'b1, MAX32, MAX16, MAX32, MAX32,
                                             MAX32, 4'hF}, 1'b1,
                                  result_t'{IND_NONE, 1'b0, 1'b0, FK_INACTIVITY, 1'b0, 1'b0,
                                            1'b0, 1'b0, ST_WAIT_MD, COND_NONE, 1'b0, 32'd0}});
        directed_rows.push_back('{in_item_t'{ACT_METADATA, 1'b1, 32'd0, 16'd0, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        // Now waiting for EOF: metadata and entered are out of phase.
        directed_rows.push_back('{in_item_t'{ACT_METADATA, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        directed_rows.push_back('{in_item_t'{ACT_ENTERED, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        // A segment without file data does not move the high-water mark.
        directed_rows.push_back('{in_item_t'{ACT_FILEDATA, 1'b0, MAX32, MAX16, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        directed_rows.push_back('{in_item_t'{ACT_FILEDATA, 1'b1, 32'd0, 16'd0, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        directed_rows.push_back('{in_item_t'{ACT_FILEDATA, 1'b1, 32'd100, 16'd50, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        directed_rows.push_back('{in_item_t'{ACT_FILEDATA, 1'b1, 32'd20, 16'd10, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        // High-water mark 150: one byte short is a size fault, then a checksum fault.
        directed_rows.push_back('{in_item_t'{ACT_EOF_OK, 1'b1, 32'd0, 16'd0, 32'd149, 32'd0,
                                             32'd0, 4'd0}, 1'b1,
                                  result_t'{IND_EOF, 1'b0, 1'b1, FK_FILE_SIZE, 1'b0, 1'b0,
                                            1'b0, 1'b0, ST_WAIT_EOF, COND_NONE, 1'b0,
                                            32'd150}});
        directed_rows.push_back('{in_item_t'{ACT_EOF_OK, 1'b1, 32'd0, 16'd0, 32'd150, 32'd1,
                                             32'd2, 4'd0}, 1'b1,
                                  result_t'{IND_EOF, 1'b0, 1'b1, FK_CHECKSUM, 1'b0, 1'b0,
                                            1'b0, 1'b0, ST_WAIT_EOF, COND_NONE, 1'b0,
                                            32'd150}});
        // Size is checked first even when the checksums agree.
        directed_rows.push_back('{in_item_t'{ACT_EOF_OK, 1'b1, 32'd0, 16'd0, 32'd0, 32'd5,
                                             32'd5, 4'd0}, 1'b0, '0});
        directed_rows.push_back('{in_item_t'{ACT_TIMEOUT, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        directed_rows.push_back('{in_item_t'{ACT_REPORT, 1'b0, 32'd0, 16'd0, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        closing_start = directed_rows.size();
        // Closing rows: an end that lands exactly on the top, one that saturates,
        // then a size fault against the saturated mark.
        directed_rows.push_back('{in_item_t'{ACT_FILEDATA, 1'b1, 32'hFFFF_FF00, 16'h00FF,
                                             32'd0, 32'd0, 32'd0, 4'd0}, 1'b0, '0});
        directed_rows.push_back('{in_item_t'{ACT_FILEDATA, 1'b1, MAX32, MAX16, 32'd0, 32'd0,
                                             32'd0, 4'd0}, 1'b0, '0});
        directed_rows.push_back('{in_item_t'{ACT_EOF_OK, 1'b1, 32'd0, 16'd0, MAX32 - 32'd1,
                                             32'd0, 32'd0, 4'd0}, 1'b0, '0});

        // Hold reset, then release it at an edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < closing_start; i++)
            send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        repeat (RANDOM_EVENTS) send_random_event();

        for (int i = closing_start; i < directed_rows.size(); i++)
            send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        // One event that completes the transaction, chosen at random.
        ev = random_fields();
        case ($urandom_range(0, 4))
            0: ev.action = ACT_ABANDON;
            1: ev.action = ACT_CANCEL_NOTE;
            2: ev.action = ACT_EOF_CANCEL;
            3:
            begin
                ev.action               = ACT_EOF_OK;
                ev.transfer_in_progress = 1'b0;
            end
            default:
            begin
                ev.action               = ACT_EOF_OK;
                ev.transfer_in_progress = 1'b1;
                ev.eof_file_size = (hw_mark > 32'hFFFF_FF00) ? MAX32
                                                             : hw_mark + $urandom_range(0, 255);
                ev.computed_checksum = ev.eof_checksum;
            end
        endcase
        send_event(ev, 1'b0, '0);

        // Completed: every code must now be ignored.
        for (code = 5'(ACT_ENTERED); code <= 5'(ACT_LAST_UNSUP); code++)
        begin
            ev        = random_fields();
            ev.action = code[3:0];
            send_event(ev, 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Drain, then allow for any stray result.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_file_delivery_receiver_fsm passed");
        else
            $display("tb_file_delivery_receiver_fsm failed");
        $finish;
    end

endmodule
